### src/cpde_pkg.sv
package cpde_pkg;

  // Store geometry
  localparam int unsigned MAX_IN_CAPS  = 256;
  localparam int unsigned MAX_OUT_CAPS = 16;
  localparam int unsigned MAX_OUT_DIM  = 16;
  localparam int unsigned MAX_IN_DIM   = 8;

  localparam int unsigned W_DEPTH = MAX_IN_CAPS * MAX_OUT_CAPS * MAX_OUT_DIM * MAX_IN_DIM;
  localparam int unsigned X_DEPTH = MAX_IN_CAPS * MAX_IN_DIM;
  localparam int unsigned W_AW    = $clog2(W_DEPTH);
  localparam int unsigned X_AW    = $clog2(X_DEPTH);

  // Field widths
  localparam int unsigned OP_W    = 2;
  localparam int unsigned CI_W    = 8;
  localparam int unsigned CJ_W    = 4;
  localparam int unsigned E_W     = 4;
  localparam int unsigned V_W     = 3;
  localparam int unsigned DATA_W  = 16;
  localparam int unsigned LEN_W   = 4;
  localparam int unsigned RES_W   = 32;

  // Arithmetic: Q3.12 * Q1.14 products, summed, then >> 10 to Q15.16
  localparam int unsigned PROD_W  = 2 * DATA_W;
  localparam int unsigned ACC_W   = PROD_W + $clog2(MAX_IN_DIM) + 1;
  localparam int unsigned SHIFT   = 10;
  // width of the shifted sum before clipping
  localparam int unsigned Q_W     = ACC_W - SHIFT;

  localparam logic [LEN_W-1:0] LEN_RESET = LEN_W'(MAX_IN_DIM);

  typedef enum logic [OP_W-1:0] {
    OP_WR_WEIGHT = 2'd0,
    OP_WR_INPUT  = 2'd1,
    OP_COMPUTE   = 2'd2
  } opcode_e;

  // Read-issue tag that travels with the memory read data
  typedef struct packed {
    logic vld;
    logic last;
  } mac_ctl_t;

  // Finished dot product
  typedef struct packed {
    logic             vld;
    logic [RES_W-1:0] value;
    logic             sat;
  } mac_res_t;

endpackage

### src/cpde_ram.sv
module cpde_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned WIDTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### src/cpde_mac.sv
module cpde_mac (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  clear_i,
  input  cpde_pkg::mac_ctl_t                    issue_i,
  input  logic signed [cpde_pkg::DATA_W-1:0]    x_i,
  input  logic signed [cpde_pkg::DATA_W-1:0]    w_i,
  output cpde_pkg::mac_res_t                    res_o
);

  cpde_pkg::mac_ctl_t                       s1_q, s2_q;
  logic signed [cpde_pkg::PROD_W-1:0]       prod_q;
  logic signed [cpde_pkg::ACC_W-1:0]        acc_q;
  logic signed [cpde_pkg::ACC_W-1:0]        sum;
  logic signed [cpde_pkg::Q_W-1:0]          quo;
  logic signed [63:0]                       quo_ext;
  logic [cpde_pkg::RES_W-1:0]               value;
  logic                                     sat;

  // tag aligned with the memory read data, then with the product
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
      s2_q <= '0;
    end else begin
      s1_q <= issue_i;
      s2_q <= s1_q;
    end
  end

  // multiplier stage
  always_ff @(posedge clk_i) begin
    if (s1_q.vld) begin
      prod_q <= x_i * w_i;
    end
  end

  assign sum = acc_q + cpde_pkg::ACC_W'(prod_q);

  // accumulator
  always_ff @(posedge clk_i) begin
    if (clear_i) begin
      acc_q <= '0;
    end else if (s2_q.vld) begin
      acc_q <= sum;
    end
  end

  // floor shift and clip to signed 32 bits
  always_comb begin
    quo     = cpde_pkg::Q_W'(sum >>> cpde_pkg::SHIFT);
    quo_ext = 64'(quo);
    sat     = 1'b0;
    value   = quo_ext[cpde_pkg::RES_W-1:0];
    if (quo_ext > 64'sh0000_0000_7FFF_FFFF) begin
      sat   = 1'b1;
      value = {1'b0, {(cpde_pkg::RES_W-1){1'b1}}};
    end else if (quo_ext < -64'sh0000_0000_8000_0000) begin
      sat   = 1'b1;
      value = {1'b1, {(cpde_pkg::RES_W-1){1'b0}}};
    end
  end

  assign res_o.vld   = s2_q.vld & s2_q.last;
  assign res_o.value = value;
  assign res_o.sat   = sat;

endmodule

### src/capsule_prediction_dot_engine.sv
// Weight and input writes are taken while the block is idle; opcode three is taken and dropped.
// A compute beat holds the input until its result is registered; it reads n pairs (n = in_dim_used,
// capped at 8) through the single multiply-accumulate unit, one weight/input pair per cycle;
// n = 0 loads a zero result into the result register on acceptance, without the unit.
// Reset clears control state and sets in_dim_used to 8; the stores are not cleared.
module capsule_prediction_dot_engine (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [cpde_pkg::LEN_W-1:0]          cfg_in_dim_used_i,
  // request channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [cpde_pkg::OP_W-1:0]           opcode_i,
  input  logic [cpde_pkg::CI_W-1:0]           src_capsule_i,
  input  logic [cpde_pkg::CJ_W-1:0]           dst_capsule_i,
  input  logic [cpde_pkg::E_W-1:0]            dst_element_i,
  input  logic [cpde_pkg::V_W-1:0]            src_element_i,
  input  logic signed [cpde_pkg::DATA_W-1:0]  data_value_i,
  // result channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [cpde_pkg::RES_W-1:0]   product_value_o,
  output logic                                saturated_o,
  output logic [cpde_pkg::CI_W-1:0]           tag_src_capsule_o,
  output logic [cpde_pkg::CJ_W-1:0]           tag_dst_capsule_o,
  output logic [cpde_pkg::E_W-1:0]            tag_dst_element_o
);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_WAIT  = 3'b100
  } state_e;

  state_e                          state_q, state_d;
  logic [cpde_pkg::LEN_W-1:0]      in_dim_used_q;
  logic [cpde_pkg::LEN_W-1:0]      len_q, len_d, len_cap;
  logic [cpde_pkg::LEN_W-1:0]      k_q, k_d;
  logic [cpde_pkg::CI_W-1:0]       ci_q;
  logic [cpde_pkg::CJ_W-1:0]       cj_q;
  logic [cpde_pkg::E_W-1:0]        e_q;

  logic                            out_valid_q, out_valid_d;
  logic [cpde_pkg::RES_W-1:0]      product_q;
  logic                            sat_q;
  logic [cpde_pkg::CI_W-1:0]       tag_ci_q;
  logic [cpde_pkg::CJ_W-1:0]       tag_cj_q;
  logic [cpde_pkg::E_W-1:0]        tag_e_q;

  cpde_pkg::opcode_e               op;
  logic                            in_fire, cmp_fire, zero_len, last_issue;
  logic                            load_zero, load_mac;
  logic                            w_we, x_we, rd_en;
  logic [cpde_pkg::W_AW-1:0]       w_waddr, w_raddr;
  logic [cpde_pkg::X_AW-1:0]       x_waddr, x_raddr;
  logic signed [cpde_pkg::DATA_W-1:0] w_rdata, x_rdata;
  cpde_pkg::mac_ctl_t              issue;
  cpde_pkg::mac_res_t              mac_res;

  // configuration register
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_dim_used_q <= cpde_pkg::LEN_RESET;
    end else if (cfg_valid_i) begin
      in_dim_used_q <= cfg_in_dim_used_i;
    end
  end

  assign len_cap = (in_dim_used_q > cpde_pkg::LEN_W'(cpde_pkg::MAX_IN_DIM)) ?
                   cpde_pkg::LEN_W'(cpde_pkg::MAX_IN_DIM) : in_dim_used_q;

  // request handshake: a compute waits until the result slot is free
  assign op         = cpde_pkg::opcode_e'(opcode_i);
  assign in_ready_o = (state_q == ST_IDLE) &&
                      ((op != cpde_pkg::OP_COMPUTE) || !out_valid_q || out_ready_i);
  assign in_fire    = in_valid_i & in_ready_o;
  assign cmp_fire   = in_fire & (op == cpde_pkg::OP_COMPUTE);
  assign zero_len   = (len_cap == '0);

  // store writes
  assign w_we    = in_fire & (op == cpde_pkg::OP_WR_WEIGHT);
  assign x_we    = in_fire & (op == cpde_pkg::OP_WR_INPUT);
  assign w_waddr = {src_capsule_i, dst_capsule_i, dst_element_i, src_element_i};
  assign x_waddr = {src_capsule_i, src_element_i};

  // read issue, one pair per cycle
  assign rd_en      = (state_q == ST_ISSUE);
  assign last_issue = (k_q == len_q - cpde_pkg::LEN_W'(1));
  assign w_raddr    = {ci_q, cj_q, e_q, k_q[cpde_pkg::V_W-1:0]};
  assign x_raddr    = {ci_q, k_q[cpde_pkg::V_W-1:0]};
  assign issue.vld  = rd_en;
  assign issue.last = rd_en & last_issue;

  cpde_ram #(
    .DEPTH (cpde_pkg::W_DEPTH),
    .WIDTH (cpde_pkg::DATA_W)
  ) u_weight_ram (
    .clk_i   (clk_i),
    .we_i    (w_we),
    .waddr_i (w_waddr),
    .wdata_i (data_value_i),
    .re_i    (rd_en),
    .raddr_i (w_raddr),
    .rdata_o (w_rdata)
  );

  cpde_ram #(
    .DEPTH (cpde_pkg::X_DEPTH),
    .WIDTH (cpde_pkg::DATA_W)
  ) u_input_ram (
    .clk_i   (clk_i),
    .we_i    (x_we),
    .waddr_i (x_waddr),
    .wdata_i (data_value_i),
    .re_i    (rd_en),
    .raddr_i (x_raddr),
    .rdata_o (x_rdata)
  );

  cpde_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clear_i (cmp_fire),
    .issue_i (issue),
    .x_i     (x_rdata),
    .w_i     (w_rdata),
    .res_o   (mac_res)
  );

  // sequencer
  always_comb begin
    state_d = state_q;
    k_d     = k_q;
    len_d   = len_q;
    case (state_q)
      ST_IDLE: begin
        if (cmp_fire && !zero_len) begin
          state_d = ST_ISSUE;
          k_d     = '0;
          len_d   = len_cap;
        end
      end
      ST_ISSUE: begin
        k_d = k_q + cpde_pkg::LEN_W'(1);
        if (last_issue) begin
          state_d = ST_WAIT;
        end
      end
      ST_WAIT: begin
        if (mac_res.vld) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      k_q     <= '0;
      len_q   <= '0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      len_q   <= len_d;
    end
  end

  // request indices
  always_ff @(posedge clk_i) begin
    if (cmp_fire) begin
      ci_q <= src_capsule_i;
      cj_q <= dst_capsule_i;
      e_q  <= dst_element_i;
    end
  end

  // result register
  assign load_zero   = cmp_fire & zero_len;
  assign load_mac    = (state_q == ST_WAIT) & mac_res.vld;
  assign out_valid_d = (load_zero | load_mac) ? 1'b1 :
                       (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_zero) begin
      product_q <= '0;
      sat_q     <= 1'b0;
      tag_ci_q  <= src_capsule_i;
      tag_cj_q  <= dst_capsule_i;
      tag_e_q   <= dst_element_i;
    end else if (load_mac) begin
      product_q <= mac_res.value;
      sat_q     <= mac_res.sat;
      tag_ci_q  <= ci_q;
      tag_cj_q  <= cj_q;
      tag_e_q   <= e_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign product_value_o   = product_q;
  assign saturated_o       = sat_q;
  assign tag_src_capsule_o = tag_ci_q;
  assign tag_dst_capsule_o = tag_cj_q;
  assign tag_dst_element_o = tag_e_q;

endmodule

### tb/capsule_prediction_dot_engine_test.sv
module capsule_prediction_dot_engine_test;
  import cpde_pkg::*;

  // opcode three: taken by the block and dropped
  localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;
  // longest compute latency plus margin, waited out before a register write
  localparam int unsigned DRAIN_CYCLES = MAX_IN_DIM + 6;
  localparam int unsigned HOLD_CYCLES  = 400;

  typedef struct {
    logic [OP_W-1:0]          op;
    logic [CI_W-1:0]          ci;
    logic [CJ_W-1:0]          cj;
    logic [E_W-1:0]           e;
    logic [V_W-1:0]           v;
    logic signed [DATA_W-1:0] data;
  } request_t;

  typedef struct {
    logic signed [RES_W-1:0] value;
    logic                    sat;
    logic [CI_W-1:0]         ci;
    logic [CJ_W-1:0]         cj;
    logic [E_W-1:0]          e;
  } dot_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [LEN_W-1:0]         cfg_in_dim_used_i = LEN_RESET;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic [OP_W-1:0]          opcode_i = OP_IGNORED;
  logic [CI_W-1:0]          src_capsule_i = '0;
  logic [CJ_W-1:0]          dst_capsule_i = '0;
  logic [E_W-1:0]           dst_element_i = '0;
  logic [V_W-1:0]           src_element_i = '0;
  logic signed [DATA_W-1:0] data_value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic signed [RES_W-1:0]  product_value_o;
  logic                     saturated_o;
  logic [CI_W-1:0]          tag_src_capsule_o;
  logic [CJ_W-1:0]          tag_dst_capsule_o;
  logic [E_W-1:0]           tag_dst_element_o;

  // request beats waiting to be driven, and dot products still owed by the block
  request_t request_q[$];
  request_t cur_req;
  dot_t     dot_expect_q[$];
  dot_t     want;

  // predictor state: both stores and the length register
  logic signed [DATA_W-1:0] weight_mem [int unsigned];
  logic signed [DATA_W-1:0] input_mem [int unsigned];
  logic [LEN_W-1:0]         dim_len = LEN_RESET;

  // stimulus bookkeeping: which entries hold data, which capsules/triples are complete
  bit              weight_set [int unsigned];
  bit              input_set [int unsigned];
  logic [CI_W-1:0] full_caps_q[$];
  logic [15:0]     full_triples_q[$];

  int   beats_sent   = 0;
  int   dots_checked = 0;
  int   mismatches   = 0;
  int   gen_count    = 0;
  logic rx_hold      = 1'b0;
  logic calm;

  // no random idling on either side for a stretch in mid-run
  assign calm = (beats_sent >= 450) && (beats_sent < 650);

  capsule_prediction_dot_engine uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_in_dim_used_i (cfg_in_dim_used_i),
    .in_valid_i        (in_valid_i),
    .in_ready_o        (in_ready_o),
    .opcode_i          (opcode_i),
    .src_capsule_i     (src_capsule_i),
    .dst_capsule_i     (dst_capsule_i),
    .dst_element_i     (dst_element_i),
    .src_element_i     (src_element_i),
    .data_value_i      (data_value_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .product_value_o   (product_value_o),
    .saturated_o       (saturated_o),
    .tag_src_capsule_o (tag_src_capsule_o),
    .tag_dst_capsule_o (tag_dst_capsule_o),
    .tag_dst_element_o (tag_dst_element_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int unsigned w_index(logic [CI_W-1:0] ci, logic [CJ_W-1:0] cj,
                                          logic [E_W-1:0] e, int unsigned v);
    return ((int'(ci) * MAX_OUT_CAPS + int'(cj)) * MAX_OUT_DIM + int'(e)) * MAX_IN_DIM + v;
  endfunction

  function automatic int unsigned x_index(logic [CI_W-1:0] ci, int unsigned v);
    return int'(ci) * MAX_IN_DIM + v;
  endfunction

  // lengths above the store depth run as the full depth
  function automatic int unsigned eff_len(logic [LEN_W-1:0] len);
    return (int'(len) > MAX_IN_DIM) ? MAX_IN_DIM : int'(len);
  endfunction

  // Apply one accepted beat to the stores; a compute yields the floored, clipped dot
  function automatic void predict_dot(request_t r);
    longint      acc;
    longint      q;
    int unsigned n;
    int unsigned k;
    dot_t        d;
    case (r.op)
      OP_WR_WEIGHT: weight_mem[w_index(r.ci, r.cj, r.e, r.v)] = r.data;
      OP_WR_INPUT:  input_mem[x_index(r.ci, r.v)] = r.data;
      OP_COMPUTE: begin
        acc = 0;
        n = eff_len(dim_len);
        for (k = 0; k < n; k++) begin
          acc += longint'(input_mem[x_index(r.ci, k)]) *
                 longint'(weight_mem[w_index(r.ci, r.cj, r.e, k)]);
        end
        q = acc >>> SHIFT;
        d.sat = 1'b0;
        if (q > 64'sd2147483647) begin
          q = 64'sd2147483647;
          d.sat = 1'b1;
        end else if (q < -64'sd2147483648) begin
          q = -64'sd2147483648;
          d.sat = 1'b1;
        end
        d.value = q[RES_W-1:0];
        d.ci = r.ci;
        d.cj = r.cj;
        d.e  = r.e;
        dot_expect_q.push_back(d);
      end
      default: ;
    endcase
  endfunction

  // ---------------- stimulus generation ----------------

  function automatic logic signed [DATA_W-1:0] rand_data();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 10) return 16'sh7fff;
    if (roll < 20) return 16'sh8000;
    if (roll < 25) return 16'sh0000;
    if (roll < 30) return 16'shffff;
    return DATA_W'($urandom);
  endfunction

  function automatic void push_req(logic [OP_W-1:0] op, logic [CI_W-1:0] ci,
                                   logic [CJ_W-1:0] cj, logic [E_W-1:0] e,
                                   logic [V_W-1:0] v, logic signed [DATA_W-1:0] data);
    request_t r;
    r.op = op;
    r.ci = ci;
    r.cj = cj;
    r.e = e;
    r.v = v;
    r.data = data;
    request_q.push_back(r);
    if (op == OP_WR_WEIGHT) weight_set[w_index(ci, cj, e, v)] = 1'b1;
    if (op == OP_WR_INPUT) input_set[x_index(ci, v)] = 1'b1;
    if (op != OP_IGNORED) gen_count++;
  endfunction

  // a compute only goes out when every entry it reads holds data
  function automatic bit can_compute(logic [CI_W-1:0] ci, logic [CJ_W-1:0] cj,
                                     logic [E_W-1:0] e);
    int unsigned k;
    for (k = 0; k < eff_len(dim_len); k++) begin
      if (!input_set.exists(x_index(ci, k)) || !weight_set.exists(w_index(ci, cj, e, k)))
        return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic void push_compute(logic [CI_W-1:0] ci, logic [CJ_W-1:0] cj,
                                       logic [E_W-1:0] e);
    if (can_compute(ci, cj, e))
      push_req(OP_COMPUTE, ci, cj, e, V_W'($urandom), DATA_W'($urandom));
  endfunction

  // elements 0..cnt-1 of one input capsule, in shuffled order
  function automatic void write_inputs(logic [CI_W-1:0] ci, int unsigned cnt);
    int unsigned order[$];
    int unsigned k;
    for (k = 0; k < cnt; k++) order.push_back(k);
    order.shuffle();
    foreach (order[i])
      push_req(OP_WR_INPUT, ci, CJ_W'($urandom), E_W'($urandom), V_W'(order[i]), rand_data());
    if (cnt == MAX_IN_DIM) full_caps_q.push_back(ci);
  endfunction

  // weights 0..cnt-1 of one (ci, cj, e) row, in shuffled order
  function automatic void write_weights(logic [CI_W-1:0] ci, logic [CJ_W-1:0] cj,
                                        logic [E_W-1:0] e, int unsigned cnt);
    int unsigned order[$];
    int unsigned k;
    for (k = 0; k < cnt; k++) order.push_back(k);
    order.shuffle();
    foreach (order[i]) push_req(OP_WR_WEIGHT, ci, cj, e, V_W'(order[i]), rand_data());
    if (cnt == MAX_IN_DIM) full_triples_q.push_back({ci, cj, e});
  endfunction

  // Mostly complete load-then-compute sequences; some noise and cut-short loads
  function automatic void gen_mix(int target);
    int              start;
    int unsigned     roll;
    int unsigned     cnt;
    logic [CI_W-1:0] ci;
    logic [CJ_W-1:0] cj;
    logic [E_W-1:0]  e;
    logic [15:0]     key;
    start = gen_count;
    while (gen_count - start < target) begin
      roll = $urandom_range(99);
      ci = CI_W'($urandom);
      cj = CJ_W'($urandom);
      e  = E_W'($urandom);
      if (roll < 10 || full_caps_q.size() == 0) begin
        write_inputs(ci, MAX_IN_DIM);
      end else if (roll < 45) begin
        ci = full_caps_q[$urandom_range(full_caps_q.size() - 1)];
        write_weights(ci, cj, e, MAX_IN_DIM);
        push_compute(ci, cj, e);
      end else if (roll < 75) begin
        repeat ($urandom_range(1, 3)) begin
          if (full_triples_q.size() > 0 && $urandom_range(3) != 0)
            key = full_triples_q[$urandom_range(full_triples_q.size() - 1)];
          else
            key = 16'($urandom);
          push_compute(key[15:8], key[7:4], key[3:0]);
        end
      end else if (roll < 85) begin
        push_req(($urandom_range(1) == 0) ? OP_WR_WEIGHT : OP_WR_INPUT, ci, cj, e,
                 V_W'($urandom), rand_data());
      end else if (roll < 92) begin
        push_req(OP_IGNORED, ci, cj, e, V_W'($urandom), DATA_W'($urandom));
      end else begin
        // load cut short: only short lengths can compute on it
        cnt = $urandom_range(1, MAX_IN_DIM - 1);
        write_inputs(ci, cnt);
        write_weights(ci, cj, e, cnt);
        push_compute(ci, cj, e);
      end
    end
  endfunction

  task automatic wait_idle();
    wait (request_q.size() == 0 && !in_valid_i && dot_expect_q.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // write the length register while idle, then stream one batch of beats
  task automatic run_phase(logic [LEN_W-1:0] len, int target);
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_in_dim_used_i <= len;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    dim_len = len;
    gen_mix(target);
    wait_idle();
  endtask

  initial begin
    int unsigned k;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: most negative operands everywhere, then mixed extremes, top indexes
    for (k = 0; k < MAX_IN_DIM; k++)
      push_req(OP_WR_INPUT, 8'hff, 4'hf, 4'hf, V_W'(k), 16'sh8000);
    full_caps_q.push_back(8'hff);
    for (k = 0; k < MAX_IN_DIM; k++)
      push_req(OP_WR_WEIGHT, 8'hff, 4'hf, 4'hf, V_W'(k), 16'sh8000);
    full_triples_q.push_back(16'hffff);
    push_compute(8'hff, 4'hf, 4'hf);
    push_req(OP_IGNORED, 8'hff, 4'hf, 4'hf, 3'h7, 16'shffff);
    for (k = 0; k < MAX_IN_DIM / 2; k++)
      push_req(OP_WR_WEIGHT, 8'hff, 4'hf, 4'hf, V_W'(k), 16'sh7fff);
    push_compute(8'hff, 4'hf, 4'hf);
    push_req(OP_COMPUTE, 8'hff, 4'hf, 4'hf, 3'h0, 16'sh0000);
    wait_idle();

    // random batches over several lengths: empty, shortest, over-range, full depth
    run_phase(4'd0, 40);
    run_phase(4'd1, 150);
    run_phase(4'd15, 200);
    run_phase(4'd3, 130);
    run_phase(4'd8, 200);
    run_phase(4'd6, 80);

    $display("covered %0d request beats and %0d dot products checked,", beats_sent,
             dots_checked);
    $display("lengths 8, 0, 1, 15, 3, 8, 6 with a %0d-cycle result stall", HOLD_CYCLES);
    if (mismatches == 0 && dot_expect_q.size() == 0) begin
      $display("capsule_prediction_dot_engine: match");
    end else begin
      $display("capsule_prediction_dot_engine: mismatch");
    end
    $finish;
  end

  // Request driver: holds each beat until taken, then predicts it
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        predict_dot(cur_req);
        beats_sent++;
      end
      if (!in_valid_i || in_ready_o) begin
        if (request_q.size() > 0 && (calm || $urandom_range(99) >= 7)) begin
          cur_req = request_q.pop_front();
          in_valid_i    <= 1'b1;
          opcode_i      <= cur_req.op;
          src_capsule_i <= cur_req.ci;
          dst_capsule_i <= cur_req.cj;
          dst_element_i <= cur_req.e;
          src_element_i <= cur_req.v;
          data_value_i  <= cur_req.data;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor: each taken beat against the oldest owed dot product
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        if (dot_expect_q.size() == 0) begin
          $error("result beat with none owed: value %0d tags %0d/%0d/%0d", product_value_o,
                 tag_src_capsule_o, tag_dst_capsule_o, tag_dst_element_o);
          mismatches++;
        end else begin
          want = dot_expect_q.pop_front();
          dots_checked++;
          if (product_value_o !== want.value) begin
            $error("product_value: expected %0d, got %0d", want.value, product_value_o);
            mismatches++;
          end
          if (saturated_o !== want.sat) begin
            $error("saturated: expected %0d, got %0d", want.sat, saturated_o);
            mismatches++;
          end
          if (tag_src_capsule_o !== want.ci) begin
            $error("tag_src_capsule: expected %0d, got %0d", want.ci, tag_src_capsule_o);
            mismatches++;
          end
          if (tag_dst_capsule_o !== want.cj) begin
            $error("tag_dst_capsule: expected %0d, got %0d", want.cj, tag_dst_capsule_o);
            mismatches++;
          end
          if (tag_dst_element_o !== want.e) begin
            $error("tag_dst_element: expected %0d, got %0d", want.e, tag_dst_element_o);
            mismatches++;
          end
        end
      end
      out_ready_i <= !rx_hold && (calm || $urandom_range(99) >= 7);
    end
  end

  // Long result stall while requests keep coming, so the input backs up
  initial begin
    wait (beats_sent >= 300 && request_q.size() > 60);
    @(posedge clk_i);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    rx_hold <= 1'b0;
  end

  initial begin
    #2000000;
    $display("capsule_prediction_dot_engine: mismatch");
    $finish;
  end

endmodule

### capsule_prediction_dot_engine.f
src/cpde_pkg.sv
src/cpde_ram.sv
src/cpde_mac.sv
src/capsule_prediction_dot_engine.sv
tb/capsule_prediction_dot_engine_test.sv
